### rtl/bpfl_pkg.sv
// ----------------------------------------------------------------------------
// bpfl_pkg
// Shared types, widths and constants of the Blinn-Phong fragment lighting core.
// ----------------------------------------------------------------------------
package bpfl_pkg;

    // fixed-point and color constants
    localparam int unsigned FRAC_ONE      = 16384;
    localparam int          FRAC_W        = 14;
    localparam logic [7:0]  WHITE         = 8'd255;
    localparam logic [7:0]  SHINE_DEFAULT = 8'd50;
    localparam logic [7:0]  CHAN_MAX      = 8'd255;

    // vector widths through the normalize unit
    localparam int VEC_W  = 17;            // signed vector component
    localparam int MAG_W  = 16;            // component magnitude
    localparam int SQ_W   = 34;            // sum of three squares
    localparam int ROOT_W = 17;            // floor of the root
    localparam int QUO_W  = 15;            // unsigned Q1.14 up to one
    localparam int UNIT_W = 16;            // signed Q2.14 unit component

    // pipeline depths
    localparam int SQRT_STEPS = 17;
    localparam int DIV_STEPS  = 15;
    localparam int NORM_LAT   = 2 + SQRT_STEPS + DIV_STEPS + 1;
    localparam int POW_STEPS  = 8;
    localparam int POW_LAT    = 2 * POW_STEPS;
    localparam int PIPE_LAT   = 1 + NORM_LAT + 1 + NORM_LAT + 2 + POW_LAT + 3;

    // configuration port
    localparam int CFG_W     = 48;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_EYE   = 3'd0,
        CFG_LIGHT = 3'd1,
        CFG_SPEC  = 3'd2,
        CFG_DIFF  = 3'd3,
        CFG_AMB   = 3'd4,
        CFG_SHINE = 3'd5,
        CFG_MAPEN = 3'd6
    } t_cfg_idx;

    typedef logic [2:0][VEC_W-1:0]  t_vec;
    typedef logic [2:0][UNIT_W-1:0] t_unit;

    // per-fragment data that rides beside the normalize units
    typedef struct packed {
        logic [2:0][15:0] nrm;
        logic [7:0]       shine;
        logic [2:0][7:0]  color;
    } t_side;

    // per-fragment data that rides beside the power unit
    typedef struct packed {
        logic [17:0]     diff;
        logic [2:0][7:0] color;
    } t_tail;

endpackage

### rtl/blinn_phong_fragment_lighting_core.sv
// ----------------------------------------------------------------------------
// blinn_phong_fragment_lighting_core
// Per-fragment Blinn-Phong lighting: view and half vector normalize, diffuse
// and specular dot products, specular power and per-channel color scaling.
// ----------------------------------------------------------------------------
//  channel | handshake                 | payload
//  --------+---------------------------+----------------------------------------
//  cfg     | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//  in      | i_in_valid / o_in_ready   | i_pos_*, i_norm_*, i_map_shininess,
//          |                           | i_tex_c0..2
//  out     | o_out_valid / i_out_ready | o_out_c0..2
//
//  one fragment per cycle while the second output buffer entry is empty
//  depth is set by the two normalize units (17-step root, 15-step divide each)
//  and the 16-stage power unit
//  a two-entry output buffer takes the last stage; the pipeline halts only
//  while its second entry is full, so o_in_ready is a register
//  synchronous reset clears valid and output flags and resets config registers
// ----------------------------------------------------------------------------
module blinn_phong_fragment_lighting_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [bpfl_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bpfl_pkg::CFG_W-1:0]      i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic signed [15:0]              i_pos_x,
    input  logic signed [15:0]              i_pos_y,
    input  logic signed [15:0]              i_pos_z,
    input  logic signed [15:0]              i_norm_x,
    input  logic signed [15:0]              i_norm_y,
    input  logic signed [15:0]              i_norm_z,
    input  logic [7:0]                      i_map_shininess,
    input  logic [7:0]                      i_tex_c0,
    input  logic [7:0]                      i_tex_c1,
    input  logic [7:0]                      i_tex_c2,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [7:0]                      o_out_c0,
    output logic [7:0]                      o_out_c1,
    output logic [7:0]                      o_out_c2
);
    localparam int QUO_W    = bpfl_pkg::QUO_W;
    localparam int FRAC_W   = bpfl_pkg::FRAC_W;
    localparam int NORM_LAT = bpfl_pkg::NORM_LAT;
    localparam int POW_LAT  = bpfl_pkg::POW_LAT;
    localparam int PIPE_LAT = bpfl_pkg::PIPE_LAT;
    localparam int CFG_W    = bpfl_pkg::CFG_W;

    // configuration registers
    logic [CFG_W-1:0] r_eye;
    logic [CFG_W-1:0] r_light;
    logic [CFG_W-1:0] r_ks;
    logic [CFG_W-1:0] r_kd;
    logic [CFG_W-1:0] r_ka;
    logic [7:0]       r_def_shine;
    logic [1:0]       r_map_en;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eye       <= '0;
            r_light     <= '0;
            r_ks        <= '0;
            r_kd        <= '0;
            r_ka        <= '0;
            r_def_shine <= bpfl_pkg::SHINE_DEFAULT;
            r_map_en    <= '0;
        end else if (i_cfg_valid) begin
            case (bpfl_pkg::t_cfg_idx'(i_cfg_index))
                bpfl_pkg::CFG_EYE:   r_eye       <= i_cfg_data;
                bpfl_pkg::CFG_LIGHT: r_light     <= i_cfg_data;
                bpfl_pkg::CFG_SPEC:  r_ks        <= i_cfg_data;
                bpfl_pkg::CFG_DIFF:  r_kd        <= i_cfg_data;
                bpfl_pkg::CFG_AMB:   r_ka        <= i_cfg_data;
                bpfl_pkg::CFG_SHINE: r_def_shine <= i_cfg_data[7:0];
                bpfl_pkg::CFG_MAPEN: r_map_en    <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // pipeline advance and valid line
    logic                w_en;
    logic                r_skv;
    logic [PIPE_LAT-1:0] r_vld;

    assign w_en       = !r_skv;
    assign o_in_ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[PIPE_LAT-2:0], i_in_valid};
        end
    end

    // input stage: view vector and side data
    logic [2:0][15:0]   w_pos;
    logic [2:0][15:0]   w_nrm;
    logic [2:0][7:0]    w_tex;
    bpfl_pkg::t_vec     n_view;
    bpfl_pkg::t_side    n_s0;
    bpfl_pkg::t_vec     r_view;
    bpfl_pkg::t_side    r_s0;

    assign w_pos = {i_pos_z, i_pos_y, i_pos_x};
    assign w_nrm = {i_norm_z, i_norm_y, i_norm_x};
    assign w_tex = {i_tex_c2, i_tex_c1, i_tex_c0};

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_view[i] = {r_eye[16*i+15], r_eye[16*i +: 16]}
                      - {w_pos[i][15], w_pos[i]};
        end
        n_s0.nrm   = w_nrm;
        n_s0.shine = r_map_en[0] ? i_map_shininess : r_def_shine;
        n_s0.color = r_map_en[1] ? w_tex
                   : {bpfl_pkg::WHITE, bpfl_pkg::WHITE, bpfl_pkg::WHITE};
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_view <= n_view;
            r_s0   <= n_s0;
        end
    end

    // view normalize with side data alongside
    bpfl_pkg::t_unit w_vn;
    bpfl_pkg::t_side r_d1 [NORM_LAT];

    bpfl_norm u_norm_view (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_vec  (r_view),
        .o_unit (w_vn)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d1[0] <= r_s0;
            for (int k = 1; k < NORM_LAT; k++) begin
                r_d1[k] <= r_d1[k-1];
            end
        end
    end

    // half vector sum
    bpfl_pkg::t_vec  n_hsum;
    bpfl_pkg::t_vec  r_hsum;
    bpfl_pkg::t_side r_hs;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_hsum[i] = {r_light[16*i+15], r_light[16*i +: 16]}
                      + {w_vn[i][15], w_vn[i]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_hsum <= n_hsum;
            r_hs   <= r_d1[NORM_LAT-1];
        end
    end

    // half vector normalize
    bpfl_pkg::t_unit w_hv;
    bpfl_pkg::t_side r_d2 [NORM_LAT];

    bpfl_norm u_norm_half (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_vec  (r_hsum),
        .o_unit (w_hv)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d2[0] <= r_hs;
            for (int k = 1; k < NORM_LAT; k++) begin
                r_d2[k] <= r_d2[k-1];
            end
        end
    end

    // dot product terms
    logic signed [31:0] r_ph [3];
    logic signed [31:0] r_pl [3];
    bpfl_pkg::t_side    r_ds;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r_ph[i] <= $signed(r_d2[NORM_LAT-1].nrm[i]) * $signed(w_hv[i]);
                r_pl[i] <= $signed(r_d2[NORM_LAT-1].nrm[i])
                         * $signed(r_light[16*i +: 16]);
            end
            r_ds <= r_d2[NORM_LAT-1];
        end
    end

    // dot sums, clamp and specular base
    logic signed [33:0] w_sh;
    logic signed [33:0] w_sl;
    logic signed [33:0] w_shs;
    logic [QUO_W-1:0]   n_base;
    logic [17:0]        n_diff;
    logic [QUO_W-1:0]   r_base;
    logic [7:0]         r_shine;
    bpfl_pkg::t_tail    r_tail;

    always_comb begin
        w_sh  = 34'(r_ph[0]) + 34'(r_ph[1]) + 34'(r_ph[2]);
        w_sl  = 34'(r_pl[0]) + 34'(r_pl[1]) + 34'(r_pl[2]);
        w_shs = w_sh >>> FRAC_W;
        if (w_sh <= 0) begin
            n_base = '0;
        end else if (w_shs > 34'(bpfl_pkg::FRAC_ONE)) begin
            n_base = QUO_W'(bpfl_pkg::FRAC_ONE);
        end else begin
            n_base = w_shs[QUO_W-1:0];
        end
        n_diff = (w_sl > 0) ? w_sl[31:14] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_base       <= n_base;
            r_shine      <= r_ds.shine;
            r_tail.diff  <= n_diff;
            r_tail.color <= r_ds.color;
        end
    end

    // specular power
    logic [QUO_W-1:0] w_spec;
    bpfl_pkg::t_tail  r_d3 [POW_LAT];

    bpfl_pow u_pow (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_base (r_base),
        .i_exp  (r_shine),
        .o_res  (w_spec)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d3[0] <= r_tail;
            for (int k = 1; k < POW_LAT; k++) begin
                r_d3[k] <= r_d3[k-1];
            end
        end
    end

    // coefficient products
    logic [30:0]     r_ksp [3];
    logic [33:0]     r_kdp [3];
    logic [2:0][7:0] r_c1;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r_ksp[i] <= r_ks[16*i +: 16] * w_spec;
                r_kdp[i] <= r_kd[16*i +: 16] * r_d3[POW_LAT-1].diff;
            end
            r_c1 <= r_d3[POW_LAT-1].color;
        end
    end

    // intensity and color product
    logic [20:0] w_inten [3];
    logic [28:0] r_cp    [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_inten[i] = 21'(r_ksp[i] >> FRAC_W) + 21'(r_kdp[i] >> FRAC_W)
                       + 21'(r_ka[16*i +: 16]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r_cp[i] <= r_c1[i] * w_inten[i];
            end
        end
    end

    // scale down and saturate
    logic [2:0][7:0] n_t3;
    logic [2:0][7:0] r_t3;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (r_cp[i][28:12] > 17'(bpfl_pkg::CHAN_MAX)) begin
                n_t3[i] = bpfl_pkg::CHAN_MAX;
            end else begin
                n_t3[i] = r_cp[i][19:12];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_t3 <= n_t3;
        end
    end

    // output register with skid entry
    logic            w_push;
    logic            w_pop;
    logic            r_oval;
    logic [2:0][7:0] r_od;
    logic [2:0][7:0] r_skd;

    assign w_push = w_en && r_vld[PIPE_LAT-1];
    assign w_pop  = r_oval && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oval <= 1'b0;
            r_skv  <= 1'b0;
        end else if (r_skv) begin
            if (w_pop) begin
                r_skv <= 1'b0;
            end
        end else if (w_push) begin
            if (r_oval && !w_pop) begin
                r_skv <= 1'b1;
            end else begin
                r_oval <= 1'b1;
            end
        end else if (w_pop) begin
            r_oval <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skv) begin
            if (w_pop) begin
                r_od <= r_skd;
            end
        end else if (w_push) begin
            if (r_oval && !w_pop) begin
                r_skd <= r_t3;
            end else begin
                r_od <= r_t3;
            end
        end
    end

    assign o_out_valid = r_oval;
    assign o_out_c0    = r_od[0];
    assign o_out_c1    = r_od[1];
    assign o_out_c2    = r_od[2];

    // skid entry is only ever filled behind a held output transaction
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skv |-> r_oval)
        else $error("skid entry full without output valid");

    // a finished fragment held by a stall is not dropped
    a_last_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[PIPE_LAT-1] && !w_en) |=> r_vld[PIPE_LAT-1])
        else $error("last stage lost its fragment during a stall");

    // a fragment pushed into an empty output shows up next cycle
    a_push_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !r_oval) |=> r_oval)
        else $error("pushed fragment did not reach the output");

endmodule

### rtl/bpfl_norm.sv
// ----------------------------------------------------------------------------
// bpfl_norm
// Pipelined 3-vector normalize: squares, sum, 17-step integer root and three
// 15-step restoring dividers; a zero vector gives zero.
// ----------------------------------------------------------------------------
module bpfl_norm (
    input  logic            i_clk,
    input  logic            i_en,
    input  bpfl_pkg::t_vec  i_vec,
    output bpfl_pkg::t_unit o_unit
);
    localparam int MAG_W  = bpfl_pkg::MAG_W;
    localparam int VEC_W  = bpfl_pkg::VEC_W;
    localparam int SQ_W   = bpfl_pkg::SQ_W;
    localparam int ROOT_W = bpfl_pkg::ROOT_W;
    localparam int QUO_W  = bpfl_pkg::QUO_W;
    localparam int UNIT_W = bpfl_pkg::UNIT_W;
    localparam int FRAC_W = bpfl_pkg::FRAC_W;
    localparam int SQ_N   = bpfl_pkg::SQRT_STEPS;
    localparam int DV_N   = bpfl_pkg::DIV_STEPS;
    localparam int REM_W  = MAG_W + FRAC_W;
    localparam int DVW    = ROOT_W + QUO_W;

    // stage 1: magnitudes and squares
    logic [2:0][VEC_W-1:0]   w_abs;
    logic [2:0]              w_neg;
    logic [2:0][MAG_W-1:0]   r_mag1;
    logic [2:0]              r_neg1;
    logic [2:0][2*MAG_W-1:0] r_sq1;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_neg[i] = i_vec[i][VEC_W-1];
            w_abs[i] = w_neg[i] ? (VEC_W'(0) - i_vec[i]) : i_vec[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_mag1[i] <= w_abs[i][MAG_W-1:0];
                r_neg1[i] <= w_neg[i];
                r_sq1[i]  <= w_abs[i][MAG_W-1:0] * w_abs[i][MAG_W-1:0];
            end
        end
    end

    // stage 2: sum of squares
    logic [SQ_W-1:0]       r_sum2;
    logic [2:0][MAG_W-1:0] r_mag2;
    logic [2:0]            r_neg2;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sum2 <= SQ_W'(r_sq1[0]) + SQ_W'(r_sq1[1]) + SQ_W'(r_sq1[2]);
            r_mag2 <= r_mag1;
            r_neg2 <= r_neg1;
        end
    end

    // root stages, one result bit each
    logic [SQ_W-1:0]       r_rs   [SQ_N];
    logic [SQ_W-1:0]       r_rr   [SQ_N];
    logic [2:0][MAG_W-1:0] r_smag [SQ_N];
    logic [2:0]            r_sneg [SQ_N];

    for (genvar g = 0; g < SQ_N; g++) begin : g_sqrt
        localparam logic [SQ_W-1:0] STEP_BIT = SQ_W'(1) << (2 * (SQ_N - 1 - g));
        logic [SQ_W-1:0]       w_s;
        logic [SQ_W-1:0]       w_r;
        logic [2:0][MAG_W-1:0] w_m;
        logic [2:0]            w_n;
        logic [SQ_W:0]         w_trial;
        logic [SQ_W-1:0]       w_sn;
        logic [SQ_W-1:0]       w_rn;

        if (g == 0) begin : g_first
            assign w_s = r_sum2;
            assign w_r = '0;
            assign w_m = r_mag2;
            assign w_n = r_neg2;
        end else begin : g_next
            assign w_s = r_rs[g-1];
            assign w_r = r_rr[g-1];
            assign w_m = r_smag[g-1];
            assign w_n = r_sneg[g-1];
        end

        // trial subtract of root plus step bit
        always_comb begin
            w_trial = {1'b0, w_r} + {1'b0, STEP_BIT};
            if ({1'b0, w_s} >= w_trial) begin
                w_sn = w_s - w_trial[SQ_W-1:0];
                w_rn = (w_r >> 1) + STEP_BIT;
            end else begin
                w_sn = w_s;
                w_rn = w_r >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rs[g]   <= w_sn;
                r_rr[g]   <= w_rn;
                r_smag[g] <= w_m;
                r_sneg[g] <= w_n;
            end
        end
    end

    // divide stages, one quotient bit per lane each
    logic [2:0][REM_W-1:0] r_drem [DV_N];
    logic [2:0][QUO_W-1:0] r_dq   [DV_N];
    logic [ROOT_W-1:0]     r_dlen [DV_N];
    logic [2:0]            r_dneg [DV_N];

    for (genvar g = 0; g < DV_N; g++) begin : g_div
        localparam int SH = DV_N - 1 - g;
        logic [2:0][REM_W-1:0] w_rem;
        logic [2:0][QUO_W-1:0] w_q;
        logic [ROOT_W-1:0]     w_len;
        logic [2:0]            w_n;
        logic [DVW-1:0]        w_dv;
        logic [2:0][REM_W-1:0] w_remn;
        logic [2:0][QUO_W-1:0] w_qn;

        if (g == 0) begin : g_first
            always_comb begin
                for (int i = 0; i < 3; i++) begin
                    w_rem[i] = {r_smag[SQ_N-1][i], FRAC_W'(0)};
                end
            end
            assign w_q   = '0;
            assign w_len = r_rr[SQ_N-1][ROOT_W-1:0];
            assign w_n   = r_sneg[SQ_N-1];
        end else begin : g_next
            assign w_rem = r_drem[g-1];
            assign w_q   = r_dq[g-1];
            assign w_len = r_dlen[g-1];
            assign w_n   = r_dneg[g-1];
        end

        // restoring step against the shifted divisor
        always_comb begin
            w_dv = DVW'(w_len) << SH;
            for (int i = 0; i < 3; i++) begin
                if (DVW'(w_rem[i]) >= w_dv) begin
                    w_remn[i] = w_rem[i] - w_dv[REM_W-1:0];
                    w_qn[i]   = w_q[i] | (QUO_W'(1) << SH);
                end else begin
                    w_remn[i] = w_rem[i];
                    w_qn[i]   = w_q[i];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_drem[g] <= w_remn;
                r_dq[g]   <= w_qn;
                r_dlen[g] <= w_len;
                r_dneg[g] <= w_n;
            end
        end
    end

    // sign and zero-vector handling
    bpfl_pkg::t_unit n_unit;
    bpfl_pkg::t_unit r_unit;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (r_dlen[DV_N-1] == '0) begin
                n_unit[i] = '0;
            end else if (r_dneg[DV_N-1][i]) begin
                n_unit[i] = UNIT_W'(0) - {1'b0, r_dq[DV_N-1][i]};
            end else begin
                n_unit[i] = {1'b0, r_dq[DV_N-1][i]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_unit <= n_unit;
        end
    end

    assign o_unit = r_unit;

endmodule

### rtl/bpfl_pow.sv
// ----------------------------------------------------------------------------
// bpfl_pow
// Pipelined Q1.14 power by MSB-first square-and-multiply, one multiply per
// stage, truncating after each product.
// ----------------------------------------------------------------------------
module bpfl_pow (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [bpfl_pkg::QUO_W-1:0]   i_base,
    input  logic [7:0]                   i_exp,
    output logic [bpfl_pkg::QUO_W-1:0]   o_res
);
    localparam int QUO_W  = bpfl_pkg::QUO_W;
    localparam int FRAC_W = bpfl_pkg::FRAC_W;
    localparam int P_N    = bpfl_pkg::POW_LAT;
    localparam int E_N    = bpfl_pkg::POW_STEPS;

    logic [QUO_W-1:0] r_pr [P_N];
    logic [QUO_W-1:0] r_pb [P_N];
    logic [7:0]       r_pe [P_N];

    for (genvar g = 0; g < P_N; g++) begin : g_stage
        logic [QUO_W-1:0]   w_r;
        logic [QUO_W-1:0]   w_b;
        logic [7:0]         w_e;
        logic [2*QUO_W-1:0] w_prod;
        logic [QUO_W-1:0]   w_rn;

        if (g == 0) begin : g_first
            assign w_r = QUO_W'(bpfl_pkg::FRAC_ONE);
            assign w_b = i_base;
            assign w_e = i_exp;
        end else begin : g_next
            assign w_r = r_pr[g-1];
            assign w_b = r_pb[g-1];
            assign w_e = r_pe[g-1];
        end

        if (g % 2 == 0) begin : g_square
            // square step
            always_comb begin
                w_prod = w_r * w_r;
                w_rn   = w_prod[FRAC_W +: QUO_W];
            end
        end else begin : g_mult
            localparam int EB = E_N - 1 - g / 2;
            // multiply step when the exponent bit is set
            always_comb begin
                w_prod = w_r * w_b;
                w_rn   = w_e[EB] ? w_prod[FRAC_W +: QUO_W] : w_r;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_pr[g] <= w_rn;
                r_pb[g] <= w_b;
                r_pe[g] <= w_e;
            end
        end
    end

    assign o_res = r_pr[P_N-1];

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Blinn-Phong fragment lighting core: fragments
// are sent with random gaps and output stalls, each one is predicted in the
// shading scoreboard, and every output transaction is compared per channel.
// ----------------------------------------------------------------------------
module tb_top;

    // one fragment as driven on the input channel
    typedef struct {
        logic signed [15:0] pos [3];
        logic signed [15:0] nrm [3];
        logic [7:0]         shine;
        logic [7:0]         tex [3];
    } t_frag;

    typedef struct {
        logic [7:0] c [3];
    } t_rgb;

    // shading predictor and queue of expected colors
    class shade_scoreboard;
        logic [47:0] eye, light, ks, kd, ka;
        logic [7:0]  def_shine;
        logic [1:0]  map_en;
        t_rgb        pending [$];
        int          errors;
        int          checked;

        function new();
            eye = '0; light = '0; ks = '0; kd = '0; ka = '0;
            def_shine = bpfl_pkg::SHINE_DEFAULT; map_en = '0;
            errors = 0; checked = 0;
        endfunction

        function void write_reg(bpfl_pkg::t_cfg_idx idx, logic [47:0] d);
            case (idx)
                bpfl_pkg::CFG_EYE:   eye = d;
                bpfl_pkg::CFG_LIGHT: light = d;
                bpfl_pkg::CFG_SPEC:  ks = d;
                bpfl_pkg::CFG_DIFF:  kd = d;
                bpfl_pkg::CFG_AMB:   ka = d;
                bpfl_pkg::CFG_SHINE: def_shine = d[7:0];
                bpfl_pkg::CFG_MAPEN: map_en = d[1:0];
                default: ;
            endcase
        endfunction

        function longint unsigned root(longint unsigned s);
            longint unsigned r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > s) b >>= 2;
            while (b != 0) begin
                if (s >= r + b) begin
                    s -= r + b;
                    r = (r >> 1) + b;
                end else begin
                    r >>= 1;
                end
                b >>= 2;
            end
            return r;
        endfunction

        // unit vector in Q2.14, zero stays zero
        function void unit_vec(input longint v [3], output longint o [3]);
            longint unsigned s, len, m;
            s = 0;
            for (int i = 0; i < 3; i++) begin
                m = v[i] < 0 ? -v[i] : v[i];
                s += m * m;
            end
            len = root(s);
            for (int i = 0; i < 3; i++) begin
                m = v[i] < 0 ? -v[i] : v[i];
                if (len == 0) o[i] = 0;
                else begin
                    m = (m * 16384) / len;
                    o[i] = v[i] < 0 ? -longint'(m) : longint'(m);
                end
            end
        endfunction

        function longint unsigned clamp_dot(longint a [3], longint b [3]);
            longint s;
            s = a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
            return s > 0 ? longint'(s >>> 14) : 0;
        endfunction

        function void note_fragment(t_frag f);
            longint nv [3], lv [3], vw [3], vn [3], hs [3], hv [3];
            longint unsigned spec, diff, r, inten, v;
            logic [7:0] e;
            logic [15:0] h;
            t_rgb res;
            for (int i = 0; i < 3; i++) begin
                nv[i] = f.nrm[i];
                h = light[16*i +: 16];
                lv[i] = longint'($signed(h));
                h = eye[16*i +: 16];
                vw[i] = longint'($signed(h)) - longint'(f.pos[i]);
            end
            unit_vec(vw, vn);
            for (int i = 0; i < 3; i++) hs[i] = lv[i] + vn[i];
            unit_vec(hs, hv);
            e = map_en[0] ? f.shine : def_shine;
            spec = clamp_dot(nv, hv);
            if (spec > 16384) spec = 16384;
            // square-and-multiply from the top exponent bit
            r = 16384;
            for (int b = 7; b >= 0; b--) begin
                r = (r * r) >> 14;
                if (e[b]) r = (r * spec) >> 14;
            end
            diff = clamp_dot(nv, lv);
            for (int i = 0; i < 3; i++) begin
                inten = ((64'(ks[16*i +: 16]) * r) >> 14)
                      + ((64'(kd[16*i +: 16]) * diff) >> 14) + 64'(ka[16*i +: 16]);
                v = ((map_en[1] ? 64'(f.tex[i]) : 64'(bpfl_pkg::WHITE)) * inten) >> 12;
                res.c[i] = v > 255 ? bpfl_pkg::CHAN_MAX : v[7:0];
            end
            pending.push_back(res);
        endfunction

        function void check_color(logic [7:0] c0, logic [7:0] c1, logic [7:0] c2);
            t_rgb exp_c;
            logic [7:0] act [3];
            act[0] = c0; act[1] = c1; act[2] = c2;
            if (pending.size() == 0) begin
                $error("output transaction with no fragment pending");
                errors++;
                return;
            end
            exp_c = pending.pop_front();
            checked++;
            for (int i = 0; i < 3; i++)
                if (act[i] !== exp_c.c[i]) begin
                    $error("out_c%0d expected %0d actual %0d", i, exp_c.c[i], act[i]);
                    errors++;
                end
        endfunction
    endclass

    logic        i_clk, i_rst_n;
    logic        i_cfg_valid, o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [47:0] i_cfg_data;
    logic        i_in_valid, o_in_ready;
    logic signed [15:0] i_pos_x, i_pos_y, i_pos_z, i_norm_x, i_norm_y, i_norm_z;
    logic [7:0]  i_map_shininess, i_tex_c0, i_tex_c1, i_tex_c2;
    logic        o_out_valid, i_out_ready;
    logic [7:0]  o_out_c0, o_out_c1, o_out_c2;

    blinn_phong_fragment_lighting_core DUT (.*);

    shade_scoreboard sb = new();
    int  idle_cycles;
    bit  calm;          // no idling on either side
    bit  hold_out;      // long receiver hold-off
    int  frags_sent;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // monitor: input and output transactions at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                t_frag f;
                f.pos[0] = i_pos_x; f.pos[1] = i_pos_y; f.pos[2] = i_pos_z;
                f.nrm[0] = i_norm_x; f.nrm[1] = i_norm_y; f.nrm[2] = i_norm_z;
                f.shine = i_map_shininess;
                f.tex[0] = i_tex_c0; f.tex[1] = i_tex_c1; f.tex[2] = i_tex_c2;
                sb.note_fragment(f);
            end
            if (o_out_valid && i_out_ready)
                sb.check_color(o_out_c0, o_out_c1, o_out_c2);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                    || (i_cfg_valid && o_cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (idle_cycles > 5000) begin
            $display("blinn_phong_fragment_lighting_core: mismatch");
            $finish;
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(negedge i_clk) begin
        if (!i_rst_n || hold_out)
            i_out_ready <= 1'b0;
        else
            i_out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 18);
    end

    initial begin
        hold_out = 1'b0;
        wait (frags_sent > 300);
        hold_out = 1'b1;
        repeat (200) @(negedge i_clk);
        hold_out = 1'b0;
    end

    task automatic cfg_write(bpfl_pkg::t_cfg_idx idx, logic [47:0] d);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.write_reg(idx, d);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // valid stays up into the next fragment unless a gap is drawn
    task automatic send_frag(t_frag f);
        if (!calm)
            while ($urandom_range(99) < 18) begin
                i_in_valid <= 1'b0;
                @(negedge i_clk);
            end
        i_in_valid <= 1'b1;
        i_pos_x <= f.pos[0]; i_pos_y <= f.pos[1]; i_pos_z <= f.pos[2];
        i_norm_x <= f.nrm[0]; i_norm_y <= f.nrm[1]; i_norm_z <= f.nrm[2];
        i_map_shininess <= f.shine;
        i_tex_c0 <= f.tex[0]; i_tex_c1 <= f.tex[1]; i_tex_c2 <= f.tex[2];
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        frags_sent++;
        @(negedge i_clk);
    endtask

    // mostly unit-scale normals in random directions, with full-range noise
    function automatic t_frag rand_frag();
        t_frag f;
        bit wide;
        wide = ($urandom_range(99) < 25);
        for (int i = 0; i < 3; i++) begin
            f.pos[i] = wide ? 16'($urandom) : 16'($signed(16'($urandom_range(8191))) - 4096);
            f.nrm[i] = wide ? 16'($urandom) : 16'($signed(16'($urandom_range(32767))) - 16384);
            f.tex[i] = 8'($urandom_range(255));
        end
        f.shine = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(64));
        return f;
    endfunction

    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (bpfl_pkg::PIPE_LAT + 10) @(negedge i_clk);
    endtask

    function automatic logic [47:0] rand_coef(int lim);
        logic [47:0] d;
        for (int i = 0; i < 3; i++) d[16*i +: 16] = 16'($urandom_range(lim));
        return d;
    endfunction

    function automatic logic [47:0] rand_vec(int lim);
        logic [47:0] d;
        for (int i = 0; i < 3; i++)
            d[16*i +: 16] = 16'($signed(16'($urandom_range(2 * lim))) - lim);
        return d;
    endfunction

    // stimulus
    initial begin
        t_frag f;
        calm = 1'b0;
        frags_sent = 0;
        idle_cycles = 0;
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0; i_cfg_index = bpfl_pkg::CFG_EYE; i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_pos_x = '0; i_pos_y = '0; i_pos_z = '0;
        i_norm_x = '0; i_norm_y = '0; i_norm_z = '0;
        i_map_shininess = '0; i_tex_c0 = '0; i_tex_c1 = '0; i_tex_c2 = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: reset settings first, then a typical light setup
        for (int ph = 0; ph < 2; ph++) begin
            if (ph == 1) begin
                drain();
                cfg_write(bpfl_pkg::CFG_EYE, {16'sd0, 16'sd0, 16'sd8192});
                cfg_write(bpfl_pkg::CFG_LIGHT, {16'sd11585, 16'sd0, 16'sd11585});
                cfg_write(bpfl_pkg::CFG_SPEC, {3{16'd4096}});
                cfg_write(bpfl_pkg::CFG_DIFF, {3{16'd3000}});
                cfg_write(bpfl_pkg::CFG_AMB, {3{16'd400}});
                cfg_write(bpfl_pkg::CFG_MAPEN, 48'd3);
            end
            for (int k = 0; k < 12; k++) begin
                for (int i = 0; i < 3; i++) begin
                    f.pos[i] = (k == 0) ? 16'sh7fff : (k == 1) ? 16'sh8000 : 16'sd0;
                    f.nrm[i] = (k == 2) ? 16'sh7fff : (k == 3) ? 16'sh8000 : 16'sd0;
                    f.tex[i] = (k == 4) ? 8'd0 : 8'd255;
                end
                if (k == 5) f.nrm[2] = 16'sd16384;       // unit normal along +z
                if (k == 6) f.pos[2] = 16'sd8192;        // fragment offset along z
                if (k == 7) begin f.nrm[0] = 16'sh7fff; f.nrm[2] = 16'sh7fff; end
                f.shine = (k == 8) ? 8'd0 : (k == 9) ? 8'd255 : 8'd1;
                if (k >= 10) f = rand_frag();
                send_frag(f);
            end
        end

        // random phases over several register settings, extremes included
        for (int ph = 0; ph < 6; ph++) begin
            drain();
            case (ph)
                0: begin
                    cfg_write(bpfl_pkg::CFG_SPEC, '1); cfg_write(bpfl_pkg::CFG_DIFF, '1);
                    cfg_write(bpfl_pkg::CFG_AMB, '1); cfg_write(bpfl_pkg::CFG_SHINE, 48'd255);
                    cfg_write(bpfl_pkg::CFG_EYE, '1); cfg_write(bpfl_pkg::CFG_LIGHT, '1);
                end
                1: begin
                    cfg_write(bpfl_pkg::CFG_SPEC, '0); cfg_write(bpfl_pkg::CFG_DIFF, '0);
                    cfg_write(bpfl_pkg::CFG_AMB, '0); cfg_write(bpfl_pkg::CFG_SHINE, 48'd0);
                    cfg_write(bpfl_pkg::CFG_EYE, {3{16'h8000}});
                    cfg_write(bpfl_pkg::CFG_LIGHT, {3{16'h7fff}});
                    cfg_write(bpfl_pkg::CFG_MAPEN, 48'd0);
                end
                default: begin
                    cfg_write(bpfl_pkg::CFG_EYE, ($urandom_range(3) == 0)
                                                 ? 48'({$urandom, $urandom})
                                                 : rand_vec(12000));
                    cfg_write(bpfl_pkg::CFG_LIGHT, rand_vec(16384));
                    cfg_write(bpfl_pkg::CFG_SPEC, rand_coef(8192));
                    cfg_write(bpfl_pkg::CFG_DIFF, rand_coef(6000));
                    cfg_write(bpfl_pkg::CFG_AMB, rand_coef(1500));
                    cfg_write(bpfl_pkg::CFG_SHINE, 48'($urandom_range(255)));
                    cfg_write(bpfl_pkg::CFG_MAPEN, 48'(ph & 3));
                end
            endcase
            calm = (ph == 3);
            for (int n = 0; n < 120; n++) send_frag(rand_frag());
        end
        calm = 1'b0;
        drain();

        $display("sent %0d fragments, checked %0d colors over 8 register settings",
                 frags_sent, sb.checked);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("blinn_phong_fragment_lighting_core: match");
        else
            $display("blinn_phong_fragment_lighting_core: mismatch");
        $finish;
    end
endmodule
